/* sv/iesort_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// iesort_pkg
// shared types and constants of the index entry sorter
// ---------------------------------------------------------------------------
package iesort_pkg;

	localparam int CAPACITY_DEF = 64;

	typedef struct packed {
		logic signed [31:0] key;
		logic signed [31:0] record_number;
		logic signed [63:0] byte_position;
		logic               final_entry;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] sorted_key;
		logic signed [31:0] sorted_record_number;
		logic signed [63:0] sorted_byte_position;
		logic               run_end;
		logic               dropped;
	} out_item_t;

	typedef struct packed {
		logic signed [31:0] key;
		logic signed [31:0] record_number;
		logic signed [63:0] byte_position;
	} entry_t;

	typedef struct packed {
		logic insert;
		logic pop;
	} cell_ctrl_t;

	typedef enum logic {
		ST_LOAD,
		ST_DRAIN
	} state_t;

endpackage
`default_nettype wire

/* sv/index_entry_sorter_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// index_entry_sorter_core
// stable insertion sorter for index entries, emits the set in key order
// ---------------------------------------------------------------------------
// usage:
//   entry channel (entry_valid / entry_stall / entry) takes one item per
//   cycle while not stalled; each item is placed into key order on arrival
//   by a chain of CAPACITY cells compared in parallel against the incoming
//   key. an item with final_entry set is stored, then the set is drained.
//   items that arrive while the chain is full are dropped and every result
//   of that set carries dropped = 1.
//   result channel (result_valid / result_stall / result) gives one item per
//   cycle while not stalled; the chain shifts down one cell per result.
//   the first result is moved into the output register after the state has
//   changed to drain; run_end marks the last result of a set.
//   entry_stall is high from the final item until the last result has been
//   moved into the output register; a stall on the result side holds the
//   output register and pauses the drain.
//   reset clears all valid bits, the drop flag and the output valid.
// ---------------------------------------------------------------------------
module index_entry_sorter_core #(
	parameter int CAPACITY = iesort_pkg::CAPACITY_DEF
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   entry_valid,
	output logic                  entry_stall,
	input  iesort_pkg::in_item_t  entry,
	output logic                  result_valid,
	input  wire                   result_stall,
	output iesort_pkg::out_item_t result
);
	import iesort_pkg::*;

	state_t     state_q;
	state_t     state_nxt;
	cell_ctrl_t ctrl;
	entry_t     new_entry;
	entry_t     cell_entry [CAPACITY];
	logic       cell_valid [CAPACITY];
	logic       cell_gt    [CAPACITY];
	logic       full;
	logic       accept;
	logic       last_pop;
	logic       overflow_q;
	logic       out_valid_q;
	out_item_t  out_q;

	assign new_entry.key           = entry.key;
	assign new_entry.record_number = entry.record_number;
	assign new_entry.byte_position = entry.byte_position;

	assign full     = cell_valid[CAPACITY-1];
	assign last_pop = ctrl.pop && !cell_valid[1];

	genvar gi;
	generate
		for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
			entry_t prev_e;
			logic   prev_v;
			logic   prev_g;
			entry_t next_e;
			logic   next_v;

			if (gi == 0) begin : g_first
				assign prev_e = new_entry;
				assign prev_v = 1'b1;
				assign prev_g = 1'b0;
			end else begin : g_mid
				assign prev_e = cell_entry[gi-1];
				assign prev_v = cell_valid[gi-1];
				assign prev_g = cell_gt[gi-1];
			end

			if (gi == CAPACITY - 1) begin : g_last
				assign next_e = new_entry;
				assign next_v = 1'b0;
			end else begin : g_inner
				assign next_e = cell_entry[gi+1];
				assign next_v = cell_valid[gi+1];
			end

			iesort_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctrl       (ctrl),
				.new_entry  (new_entry),
				.prev_entry (prev_e),
				.prev_valid (prev_v),
				.prev_gt    (prev_g),
				.next_entry (next_e),
				.next_valid (next_v),
				.entry      (cell_entry[gi]),
				.valid      (cell_valid[gi]),
				.gt         (cell_gt[gi])
			);
		end
	endgenerate

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_LOAD: begin
				if (entry_valid && entry.final_entry) begin
					state_nxt = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (last_pop || !cell_valid[0]) begin
					state_nxt = ST_LOAD;
				end
			end
			default: state_nxt = ST_LOAD;
		endcase
	end

	// outputs
	always_comb begin
		entry_stall = 1'b1;
		accept      = 1'b0;
		ctrl        = '0;
		unique case (state_q)
			ST_LOAD: begin
				entry_stall = 1'b0;
				accept      = entry_valid;
				ctrl.insert = entry_valid && !full;
			end
			ST_DRAIN: begin
				ctrl.pop = cell_valid[0] && (!out_valid_q || !result_stall);
			end
			default: begin
				entry_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			overflow_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (last_pop) begin
				overflow_q <= 1'b0;
			end else if (accept && full) begin
				overflow_q <= 1'b1;
			end
			if (ctrl.pop) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.pop) begin
			out_q.sorted_key           <= cell_entry[0].key;
			out_q.sorted_record_number <= cell_entry[0].record_number;
			out_q.sorted_byte_position <= cell_entry[0].byte_position;
			out_q.run_end              <= !cell_valid[1];
			out_q.dropped              <= overflow_q;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	// the bottom of the chain stays filled and ordered
	a_chain_order: assert property (@(posedge clk) disable iff (!arst_n)
		cell_valid[1] |-> (cell_valid[0] && (cell_entry[0].key <= cell_entry[1].key)))
		else $error("chain out of order");

	a_final_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && entry.final_entry) |=> (state_q == ST_DRAIN))
		else $error("final item did not start drain");

	a_empty_after_run: assert property (@(posedge clk) disable iff (!arst_n)
		last_pop |=> (!cell_valid[0] && !overflow_q && result.run_end))
		else $error("chain not empty after run end");

	a_no_insert_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |-> (!ctrl.insert && entry_stall))
		else $error("insert while draining");

endmodule
`default_nettype wire

/* sv/iesort_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// iesort_cell
// one slot of the insertion chain: holds an entry, shifts up on insert and
// down on drain
// ---------------------------------------------------------------------------
module iesort_cell (
	input  wire                  clk,
	input  wire                  arst_n,
	input  iesort_pkg::cell_ctrl_t ctrl,
	input  iesort_pkg::entry_t   new_entry,
	input  iesort_pkg::entry_t   prev_entry,
	input  wire                  prev_valid,
	input  wire                  prev_gt,
	input  iesort_pkg::entry_t   next_entry,
	input  wire                  next_valid,
	output iesort_pkg::entry_t   entry,
	output logic                 valid,
	output logic                 gt
);
	import iesort_pkg::*;

	entry_t entry_q;
	logic   valid_q;
	logic   open_slot;

	assign gt        = valid_q && (entry_q.key > new_entry.key);
	assign open_slot = gt || !valid_q;
	assign entry     = entry_q;
	assign valid     = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.pop) begin
			valid_q <= next_valid;
		end else if (ctrl.insert && open_slot && (prev_gt || prev_valid)) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.pop) begin
			entry_q <= next_entry;
		end else if (ctrl.insert && open_slot) begin
			if (prev_gt) begin
				entry_q <= prev_entry;
			end else if (prev_valid) begin
				entry_q <= new_entry;
			end
		end
	end

endmodule
`default_nettype wire
